@@ rtl/tcpq_pkg.sv @@
// Shared types and constants for the two-class priority queue.
// Command and status codes, controller states, and the controller/datapath link.
package tcpq_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int ID_BITS_DEF  = 16;

    // Request command codes
    typedef enum logic [1:0] {
        CMD_INSERT   = 2'd0,
        CMD_SERVE    = 2'd1,
        CMD_WITHDRAW = 2'd2,
        CMD_QUERY    = 2'd3
    } cmd_t;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_DUP      = 3'd1,
        ST_FULL     = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_NOTFOUND = 3'd4
    } status_t;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_SCAN = 2'd1,
        S_ADJ  = 2'd2,
        S_DONE = 2'd3
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;        // capture request, clear search results
        logic pass_start;  // rewind the slot walk
        logic pass_run;    // walk slots, one RAM read per cycle
        logic adjust;      // walk rewrites ranks instead of searching
        logic commit_ins;  // write the new entry
        logic commit_rem;  // drop the matched entry
        logic out_load;    // load the result register
        logic busy;        // not taking requests
    } ctl_t;

    // Datapath to controller status
    typedef struct packed {
        cmd_t cmd;
        logic pref;
        logic hit;
        logic full;
        logic pass_done;
    } sts_t;

endpackage

@@ rtl/tcpq_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module tcpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ rtl/tcpq_ctrl.sv @@
// Controller state machine for the two-class priority queue.
// Depends on tcpq_pkg; drives the datapath through ctl_t, reads sts_t back.
module tcpq_ctrl import tcpq_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    input  logic out_free,
    input  sts_t sts,
    output ctl_t ctl
);

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    ctl.load       = 1'b1;
                    ctl.pass_start = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN:
            begin
                ctl.busy = 1'b1;
                if (!sts.pass_done)
                begin
                    ctl.pass_run = 1'b1;
                end
                else
                begin
                    state_next = S_DONE;
                    case (sts.cmd)
                        CMD_INSERT:
                        begin
                            if (!sts.hit && !sts.full)
                            begin
                                if (sts.pref)
                                begin
                                    // normal entries move back one place first
                                    ctl.pass_start = 1'b1;
                                    state_next     = S_ADJ;
                                end
                                else
                                begin
                                    ctl.commit_ins = 1'b1;
                                end
                            end
                        end
                        CMD_SERVE, CMD_WITHDRAW:
                        begin
                            if (sts.hit)
                            begin
                                ctl.pass_start = 1'b1;
                                state_next     = S_ADJ;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_ADJ:
            begin
                ctl.busy   = 1'b1;
                ctl.adjust = 1'b1;
                if (!sts.pass_done)
                begin
                    ctl.pass_run = 1'b1;
                end
                else
                begin
                    if (sts.cmd == CMD_INSERT)
                    begin
                        ctl.commit_ins = 1'b1;
                    end
                    else
                    begin
                        ctl.commit_rem = 1'b1;
                    end
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                ctl.busy = 1'b1;
                if (out_free)
                begin
                    ctl.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/tcpq_dp.sv @@
// Datapath for the two-class priority queue: slot RAM, valid bits, count, slot walk.
// Depends on tcpq_pkg and tcpq_ram.
module tcpq_dp import tcpq_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int ID_BITS  = ID_BITS_DEF,
    localparam int IDXW    = $clog2(CAPACITY),
    localparam int CNTW    = $clog2(CAPACITY + 1)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  ctl_t               ctl,
    output sts_t               sts,
    input  logic [1:0]         req_cmd,
    input  logic [ID_BITS-1:0] req_id,
    input  logic               req_pref,
    output logic [2:0]         res_status,
    output logic [ID_BITS-1:0] res_id,
    output logic               res_pref,
    output logic [CNTW-1:0]    res_count
);

    localparam int WW = ID_BITS + IDXW + 1;

    // Request registers
    cmd_t               cmd_reg;
    logic [ID_BITS-1:0] key_reg;
    logic               pref_reg;
    logic               full_reg;

    // Queue state
    logic [CAPACITY-1:0] valid_reg, valid_next;
    logic [CNTW-1:0]     count_reg, count_next;

    // Slot walk
    logic [CNTW-1:0] addr_reg, addr_next;
    logic            rd_vld_reg, rd_vld_next;
    logic [IDXW-1:0] rd_idx_reg, rd_idx_next;
    logic            issue;

    // Search results
    logic               hit_reg, hit_next;
    logic [IDXW-1:0]    cap_idx_reg, cap_idx_next;
    logic [IDXW-1:0]    cap_rank_reg, cap_rank_next;
    logic               cap_pref_reg, cap_pref_next;
    logic [ID_BITS-1:0] cap_id_reg, cap_id_next;
    logic [CNTW-1:0]    npref_reg, npref_next;
    logic               free_fnd_reg, free_fnd_next;
    logic [IDXW-1:0]    free_idx_reg, free_idx_next;

    // RAM ports
    logic               wr_en;
    logic [IDXW-1:0]    wr_addr;
    logic [WW-1:0]      wr_data;
    logic [WW-1:0]      rd_data;
    logic [ID_BITS-1:0] d_id;
    logic [IDXW-1:0]    d_rank;
    logic               d_pref;
    logic               d_valid;
    logic               match;
    logic [IDXW-1:0]    ins_rank;

    // Slot word: {preferred, rank, id}
    tcpq_ram #(
        .WIDTH(WW),
        .DEPTH(CAPACITY)
    ) u_slot_ram (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_en  (issue),
        .rd_addr(addr_reg[IDXW-1:0]),
        .rd_data(rd_data)
    );

    assign d_id    = rd_data[ID_BITS-1:0];
    assign d_rank  = rd_data[ID_BITS +: IDXW];
    assign d_pref  = rd_data[WW-1];
    assign d_valid = rd_vld_reg && valid_reg[rd_idx_reg];

    // Serve looks for the head; the others look for the key
    assign match = d_valid && !hit_reg &&
                   ((cmd_reg == CMD_SERVE) ? (d_rank == '0) : (d_id == key_reg));

    assign ins_rank = pref_reg ? npref_reg[IDXW-1:0] : count_reg[IDXW-1:0];

    // Walk address: one read per cycle until every slot is issued
    assign issue = ctl.pass_run && (addr_reg != CNTW'(CAPACITY));

    always_comb
    begin
        addr_next   = addr_reg;
        rd_vld_next = issue;
        rd_idx_next = addr_reg[IDXW-1:0];
        if (ctl.pass_start)
        begin
            addr_next   = '0;
            rd_vld_next = 1'b0;
        end
        else if (issue)
        begin
            addr_next = addr_reg + CNTW'(1);
        end
    end

    // Search pass: capture match, count preferred, note first free slot
    always_comb
    begin
        hit_next      = hit_reg;
        cap_idx_next  = cap_idx_reg;
        cap_rank_next = cap_rank_reg;
        cap_pref_next = cap_pref_reg;
        cap_id_next   = cap_id_reg;
        npref_next    = npref_reg;
        free_fnd_next = free_fnd_reg;
        free_idx_next = free_idx_reg;
        if (ctl.load)
        begin
            hit_next      = 1'b0;
            npref_next    = '0;
            free_fnd_next = 1'b0;
        end
        else if (rd_vld_reg && !ctl.adjust)
        begin
            if (match)
            begin
                hit_next      = 1'b1;
                cap_idx_next  = rd_idx_reg;
                cap_rank_next = d_rank;
                cap_pref_next = d_pref;
                cap_id_next   = d_id;
            end
            if (d_valid && d_pref)
            begin
                npref_next = npref_reg + CNTW'(1);
            end
            if (!valid_reg[rd_idx_reg] && !free_fnd_reg)
            begin
                free_fnd_next = 1'b1;
                free_idx_next = rd_idx_reg;
            end
        end
    end

    // RAM write: new entry, or a rank rewrite during the adjust pass
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = rd_idx_reg;
        wr_data = {d_pref, d_rank, d_id};
        if (ctl.commit_ins)
        begin
            wr_en   = 1'b1;
            wr_addr = free_idx_reg;
            wr_data = {pref_reg, ins_rank, key_reg};
        end
        else if (ctl.adjust && d_valid)
        begin
            if (cmd_reg == CMD_INSERT)
            begin
                if (!d_pref)
                begin
                    wr_en   = 1'b1;
                    wr_data = {d_pref, d_rank + IDXW'(1), d_id};
                end
            end
            else if (d_rank > cap_rank_reg)
            begin
                wr_en   = 1'b1;
                wr_data = {d_pref, d_rank - IDXW'(1), d_id};
            end
        end
    end

    // Valid bits and entry count
    always_comb
    begin
        valid_next = valid_reg;
        count_next = count_reg;
        if (ctl.commit_ins)
        begin
            valid_next[free_idx_reg] = 1'b1;
            count_next               = count_reg + CNTW'(1);
        end
        else if (ctl.commit_rem)
        begin
            valid_next[cap_idx_reg] = 1'b0;
            count_next              = count_reg - CNTW'(1);
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            count_reg    <= '0;
            addr_reg     <= '0;
            rd_vld_reg   <= 1'b0;
            hit_reg      <= 1'b0;
            free_fnd_reg <= 1'b0;
        end
        else
        begin
            valid_reg    <= valid_next;
            count_reg    <= count_next;
            addr_reg     <= addr_next;
            rd_vld_reg   <= rd_vld_next;
            hit_reg      <= hit_next;
            free_fnd_reg <= free_fnd_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        rd_idx_reg   <= rd_idx_next;
        cap_idx_reg  <= cap_idx_next;
        cap_rank_reg <= cap_rank_next;
        cap_pref_reg <= cap_pref_next;
        cap_id_reg   <= cap_id_next;
        npref_reg    <= npref_next;
        free_idx_reg <= free_idx_next;
        if (ctl.load)
        begin
            cmd_reg  <= cmd_t'(req_cmd);
            key_reg  <= req_id;
            pref_reg <= req_pref;
            full_reg <= (count_reg == CNTW'(CAPACITY));
        end
    end

    // Status to the controller
    always_comb
    begin
        sts.cmd       = cmd_reg;
        sts.pref      = pref_reg;
        sts.hit       = hit_reg;
        sts.full      = full_reg;
        sts.pass_done = (addr_reg == CNTW'(CAPACITY)) && !rd_vld_reg;
    end

    // Result fields
    always_comb
    begin
        status_t st;
        st       = ST_OK;
        res_id   = '0;
        res_pref = 1'b0;
        case (cmd_reg)
            CMD_INSERT:
            begin
                if (hit_reg)
                begin
                    st = ST_DUP;
                end
                else if (full_reg)
                begin
                    st = ST_FULL;
                end
            end
            CMD_SERVE:
            begin
                if (hit_reg)
                begin
                    res_id   = cap_id_reg;
                    res_pref = cap_pref_reg;
                end
                else
                begin
                    st = ST_EMPTY;
                end
            end
            CMD_WITHDRAW:
            begin
                if (!hit_reg)
                begin
                    st = ST_NOTFOUND;
                end
            end
            CMD_QUERY:
            begin
                if (hit_reg)
                begin
                    res_pref = cap_pref_reg;
                end
                else
                begin
                    st = ST_NOTFOUND;
                end
            end
            default:
            begin
                st = ST_OK;
            end
        endcase
        res_status = st;
    end

    assign res_count = count_reg;

endmodule

@@ rtl/two_class_priority_queue_cancel.sv @@
// Top level of the two-class priority queue with cancel.
// Depends on tcpq_pkg, tcpq_ctrl and tcpq_dp; holds the result register.
//
//   channel   signals                                   direction
//   request   req_valid/req_stall, cmd, id, preferred   in
//   result    rsp_valid/rsp_stall, status, result_id,   out
//             result_preferred, count
//
// Each command walks every slot of the slot RAM, one read per cycle.
// Query, failed commands and normal insert walk once;
// serve, withdraw and preferred insert walk twice.
// After reset the queue is empty and a request is taken at once.
// A new request is taken while the last result still waits under rsp_stall;
// its result waits in turn until the result register frees.
module two_class_priority_queue_cancel import tcpq_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int ID_BITS  = ID_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             req_valid,
    output logic                             req_stall,
    input  logic [1:0]                       cmd,
    input  logic [ID_BITS-1:0]               id,
    input  logic                             preferred,
    output logic                             rsp_valid,
    input  logic                             rsp_stall,
    output logic [2:0]                       status,
    output logic [ID_BITS-1:0]               result_id,
    output logic                             result_preferred,
    output logic [$clog2(CAPACITY+1)-1:0]    count
);

    localparam int CNTW = $clog2(CAPACITY + 1);

    ctl_t ctl;
    sts_t sts;
    logic out_free;

    logic [2:0]         res_status;
    logic [ID_BITS-1:0] res_id;
    logic               res_pref;
    logic [CNTW-1:0]    res_count;

    logic               rsp_valid_reg, rsp_valid_next;
    logic [2:0]         status_reg;
    logic [ID_BITS-1:0] result_id_reg;
    logic               result_pref_reg;
    logic [CNTW-1:0]    count_reg;

    assign out_free = !rsp_valid_reg || !rsp_stall;

    tcpq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .out_free (out_free),
        .sts      (sts),
        .ctl      (ctl)
    );

    tcpq_dp #(
        .CAPACITY(CAPACITY),
        .ID_BITS (ID_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .sts       (sts),
        .req_cmd   (cmd),
        .req_id    (id),
        .req_pref  (preferred),
        .res_status(res_status),
        .res_id    (res_id),
        .res_pref  (res_pref),
        .res_count (res_count)
    );

    assign req_stall = ctl.busy;

    // Result register valid
    assign rsp_valid_next = ctl.out_load || (rsp_valid_reg && rsp_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (ctl.out_load)
        begin
            status_reg      <= res_status;
            result_id_reg   <= res_id;
            result_pref_reg <= res_pref;
            count_reg       <= res_count;
        end
    end

    assign rsp_valid        = rsp_valid_reg;
    assign status           = status_reg;
    assign result_id        = result_id_reg;
    assign result_preferred = result_pref_reg;
    assign count            = count_reg;

endmodule

@@ sim/tcpq_checker.sv @@
`timescale 1ns / 1ps
// Result checker for the two-class priority queue: watches both channels,
// keeps its own copy of the queue contents and compares every result.
// Depends on tcpq_pkg for the command and status codes.
module tcpq_checker import tcpq_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int ID_BITS  = ID_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    input  logic                          req_stall,
    input  logic [1:0]                    cmd,
    input  logic [ID_BITS-1:0]            id,
    input  logic                          preferred,
    input  logic                          rsp_valid,
    input  logic                          rsp_stall,
    input  logic [2:0]                    status,
    input  logic [ID_BITS-1:0]            result_id,
    input  logic                          result_preferred,
    input  logic [$clog2(CAPACITY+1)-1:0] count,
    output int                            fail_count,
    output int                            pending
);

    localparam int CW = $clog2(CAPACITY+1);

    typedef struct packed {
        int unsigned        seq;
        status_t            status;
        logic [ID_BITS-1:0] rid;
        logic               rpref;
        logic [CW-1:0]      cnt;
    } outcome_t;

    // Queue contents in service order, one line per class
    logic [ID_BITS-1:0] pref_line[$];
    logic [ID_BITS-1:0] norm_line[$];
    outcome_t           awaited[$];
    int                 errors;
    int unsigned        req_seq;

    // Position of key in its class line, -1 if not held
    function automatic int held_at(input logic [ID_BITS-1:0] key, output logic in_pref);
        int k;
        in_pref = 1'b0;
        for (k = 0; k < pref_line.size(); k++)
            if (pref_line[k] == key)
            begin
                in_pref = 1'b1;
                return k;
            end
        for (k = 0; k < norm_line.size(); k++)
            if (norm_line[k] == key)
                return k;
        return -1;
    endfunction

    // Apply one request to the queue copy and return the result it gives
    function automatic outcome_t queue_step(input cmd_t op, input logic [ID_BITS-1:0] key,
                                            input logic pref);
        outcome_t o;
        int       pos;
        logic     in_pref;
        o.seq    = req_seq;
        o.status = ST_OK;
        o.rid    = '0;
        o.rpref  = 1'b0;
        pos      = held_at(key, in_pref);
        case (op)
            CMD_INSERT:
            begin
                // duplicate check wins over the full check
                if (pos >= 0)
                    o.status = ST_DUP;
                else if (pref_line.size() + norm_line.size() >= CAPACITY)
                    o.status = ST_FULL;
                else if (pref)
                    pref_line.push_back(key);
                else
                    norm_line.push_back(key);
            end
            CMD_SERVE:
            begin
                if (pref_line.size() > 0)
                begin
                    o.rid   = pref_line.pop_front();
                    o.rpref = 1'b1;
                end
                else if (norm_line.size() > 0)
                    o.rid = norm_line.pop_front();
                else
                    o.status = ST_EMPTY;
            end
            CMD_WITHDRAW:
            begin
                if (pos < 0)
                    o.status = ST_NOTFOUND;
                else if (in_pref)
                    pref_line.delete(pos);
                else
                    norm_line.delete(pos);
            end
            default:
            begin
                if (pos < 0)
                    o.status = ST_NOTFOUND;
                else
                    o.rpref = in_pref;
            end
        endcase
        o.cnt = CW'(pref_line.size() + norm_line.size());
        return o;
    endfunction

    // Predict on each accepted request, compare on each accepted result
    always @(posedge clk or negedge rst_n)
    begin
        outcome_t want;
        if (!rst_n)
        begin
            pref_line.delete();
            norm_line.delete();
            awaited.delete();
            errors     = 0;
            req_seq    = 0;
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (req_valid && !req_stall)
            begin
                awaited.push_back(queue_step(cmd_t'(cmd), id, preferred));
                req_seq++;
            end
            if (rsp_valid && !rsp_stall)
            begin
                if (awaited.size() == 0)
                begin
                    if (errors < 10)
                        $display("%0t: result with no request outstanding: status %0d id %h",
                                 $realtime, status, result_id);
                    errors++;
                end
                else
                begin
                    want = awaited.pop_front();
                    if (status !== want.status || result_id !== want.rid ||
                        result_preferred !== want.rpref || count !== want.cnt)
                    begin
                        if (errors < 10)
                        begin
                            $display("%0t: request %0d mismatch (expected/actual):",
                                     $realtime, want.seq);
                            $display("    status %0d/%0d id %h/%h pref %0d/%0d count %0d/%0d",
                                     want.status, status, want.rid, result_id,
                                     want.rpref, result_preferred, want.cnt, count);
                        end
                        errors++;
                    end
                end
            end
            fail_count <= errors;
            pending    <= awaited.size();
        end
    end

endmodule

@@ sim/tb_two_class_priority_queue_cancel.sv @@
`timescale 1ns / 1ps
// Testbench top for two_class_priority_queue_cancel: clock, reset, request
// stimulus, result-side stall pattern and the verdict.
// Depends on tcpq_pkg, the block under test and tcpq_checker.
module tb_two_class_priority_queue_cancel;
    import tcpq_pkg::*;

    localparam int CAPACITY     = CAPACITY_DEF;
    localparam int ID_BITS      = ID_BITS_DEF;
    localparam int CW           = $clog2(CAPACITY+1);
    localparam int DRAIN_CYCLES = 2*CAPACITY + 6 + 8;
    localparam int POOL         = 24;
    localparam int PHASES       = 10;
    localparam int PHASE_ITEMS  = 125;

    logic               clk;
    logic               rst_n     = 1'b0;
    logic               req_valid = 1'b0;
    logic               req_stall;
    logic [1:0]         cmd       = CMD_INSERT;
    logic [ID_BITS-1:0] id        = '0;
    logic               preferred = 1'b0;
    logic               rsp_valid;
    logic               rsp_stall = 1'b0;
    logic [2:0]         status;
    logic [ID_BITS-1:0] result_id;
    logic               result_preferred;
    logic [CW-1:0]      count;
    int                 fail_count;
    int                 pending;

    two_class_priority_queue_cancel #(
        .CAPACITY (CAPACITY),
        .ID_BITS  (ID_BITS)
    ) i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .req_valid        (req_valid),
        .req_stall        (req_stall),
        .cmd              (cmd),
        .id               (id),
        .preferred        (preferred),
        .rsp_valid        (rsp_valid),
        .rsp_stall        (rsp_stall),
        .status           (status),
        .result_id        (result_id),
        .result_preferred (result_preferred),
        .count            (count)
    );

    tcpq_checker #(
        .CAPACITY (CAPACITY),
        .ID_BITS  (ID_BITS)
    ) i_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .req_valid        (req_valid),
        .req_stall        (req_stall),
        .cmd              (cmd),
        .id               (id),
        .preferred        (preferred),
        .rsp_valid        (rsp_valid),
        .rsp_stall        (rsp_stall),
        .status           (status),
        .result_id        (result_id),
        .result_preferred (result_preferred),
        .count            (count),
        .fail_count       (fail_count),
        .pending          (pending)
    );

    // 12 ns clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Hard limit on run length
    initial
    begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Result-side stall: open, random, or long held stretches
    int stall_mode = 0;
    int mode_left  = 0;
    int hold_left  = 0;

    always @(posedge clk)
    begin
        if (!rst_n)
            rsp_stall <= 1'b0;
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 2);
                mode_left  = $urandom_range(20, 300);
            end
            else
                mode_left--;
            case (stall_mode)
                0: rsp_stall <= 1'b0;
                1: rsp_stall <= 1'($urandom_range(0, 1));
                default:
                begin
                    if (hold_left == 0)
                    begin
                        rsp_stall <= ~rsp_stall;
                        hold_left = $urandom_range(1, 40);
                    end
                    else
                        hold_left--;
                end
            endcase
        end
    end

    // Present one request and hold it until taken
    task automatic send_req(input cmd_t c, input logic [ID_BITS-1:0] key, input logic p);
        req_valid <= 1'b1;
        cmd       <= c;
        id        <= key;
        preferred <= p;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
    endtask

    // Stop sending and wait for every outstanding result
    task automatic drain_results();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    logic [ID_BITS-1:0] id_pool [POOL];
    logic [ID_BITS-1:0] key;
    cmd_t               op;
    int                 burst_left;
    int                 lim_ins, lim_srv, lim_wd;
    int                 r;

    initial
    begin
        id_pool[0] = '0;
        id_pool[1] = '1;
        for (int k = 2; k < POOL; k++)
            id_pool[k] = ID_BITS'($urandom);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty queue cases
        send_req(CMD_SERVE, 16'h5a5a, 1'b1);
        send_req(CMD_QUERY, 16'h1234, 1'b0);
        send_req(CMD_WITHDRAW, 16'h0000, 1'b0);
        // extreme ids, both classes, duplicate with other class
        send_req(CMD_INSERT, 16'h0000, 1'b0);
        send_req(CMD_INSERT, 16'hffff, 1'b1);
        send_req(CMD_INSERT, 16'h0000, 1'b1);
        send_req(CMD_QUERY, 16'hffff, 1'b0);
        send_req(CMD_QUERY, 16'h0000, 1'b1);
        // fill to capacity, then full and duplicate-while-full
        for (int k = 1; k <= CAPACITY - 2; k++)
            send_req(CMD_INSERT, ID_BITS'(k * 16'h1357 + 16'h0101), 1'(k));
        send_req(CMD_INSERT, 16'habcd, 1'b1);
        send_req(CMD_INSERT, 16'hffff, 1'b0);
        // serve takes preferred head, withdraw hit and miss
        send_req(CMD_SERVE, 16'h0000, 1'b0);
        send_req(CMD_WITHDRAW, 16'h0000, 1'b1);
        send_req(CMD_WITHDRAW, 16'habcd, 1'b0);

        // Random phases with shifting command mix
        burst_left = $urandom_range(0, 40);
        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph % 4)
                0:       begin lim_ins = 65; lim_srv = 75; lim_wd = 90; end
                1:       begin lim_ins = 20; lim_srv = 75; lim_wd = 88; end
                2:       begin lim_ins = 30; lim_srv = 55; lim_wd = 75; end
                default: begin lim_ins = 25; lim_srv = 35; lim_wd = 70; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                r = $urandom_range(0, 99);
                if (r < lim_ins)
                    op = CMD_INSERT;
                else if (r < lim_srv)
                    op = CMD_SERVE;
                else if (r < lim_wd)
                    op = CMD_WITHDRAW;
                else
                    op = CMD_QUERY;
                // mostly pool ids so hits and duplicates are common
                if ($urandom_range(0, 99) < 85)
                    key = id_pool[$urandom_range(0, POOL-1)];
                else
                    key = ID_BITS'($urandom);
                send_req(op, key, 1'($urandom_range(0, 1)));
                // sender bursts with gaps between them
                if (burst_left > 0)
                    burst_left--;
                else
                begin
                    req_valid <= 1'b0;
                    repeat ($urandom_range(1, 15)) @(posedge clk);
                    burst_left = $urandom_range(0, 40);
                end
            end
            if (ph == PHASES / 2 - 1)
                drain_results();
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
